@@ sv/ssu_pkg.sv @@
// ----------------------------------------------------------------------------
// ssu_pkg
// Shared constants, codes and types of the scoped symbol stack unit.
// ----------------------------------------------------------------------------
package ssu_pkg;

	localparam int STORE_DEPTH = 1024;
	localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
	localparam int CNT_BITS    = ADDR_BITS + 1;
	localparam int KEY_BITS    = 32;
	localparam int VALUE_BITS  = 32;
	// data word must also hold a scope base index
	localparam int WORD_BITS   = (KEY_BITS > VALUE_BITS) ? KEY_BITS : VALUE_BITS;
	localparam int MEM_BITS    = WORD_BITS + 1;   // stash mark on top
	localparam int CMD_BITS    = 3;
	localparam int DEPTH_BITS  = 10;
	localparam int STAT_BITS   = 2;

	typedef enum logic [CMD_BITS-1:0] {
		CMD_CLEAR   = 3'd0,
		CMD_PUSH    = 3'd1,
		CMD_POP     = 3'd2,
		CMD_STASH   = 3'd3,
		CMD_UNSTASH = 3'd4,
		CMD_DEFINE  = 3'd5,
		CMD_LOOKUP  = 3'd6
	} cmd_t;

	typedef enum logic [STAT_BITS-1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_MISUSE   = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_WR2,
		S_POP_RD,
		S_UNS_MARK,
		S_UNS_BASE,
		S_LK_CHECK,
		S_LK_WORD,
		S_LK_LINK,
		S_LK_BASE,
		S_LK_VAL,
		S_DONE
	} state_t;

	typedef struct packed {
		status_t               status;
		logic [VALUE_BITS-1:0] found;
		logic [CNT_BITS-1:0]   used;
	} rsp_t;

	typedef struct packed {
		logic                 we;
		logic [ADDR_BITS-1:0] waddr;
		logic [MEM_BITS-1:0]  wdata;
		logic                 re;
		logic [ADDR_BITS-1:0] raddr;
	} mem_req_t;

endpackage

@@ sv/ssu_ram.sv @@
// ----------------------------------------------------------------------------
// ssu_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ssu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ sv/ssu_out_reg.sv @@
// ----------------------------------------------------------------------------
// ssu_out_reg
// Result holding register; frees the sequencer while the receiver stalls.
// ----------------------------------------------------------------------------
module ssu_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  ssu_pkg::rsp_t     rsp_in,
	output logic              slot_free,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output ssu_pkg::rsp_t     rsp_out
);
	import ssu_pkg::*;

	logic valid_q;
	rsp_t data_q;

	assign slot_free = !valid_q || rsp_ready;
	assign rsp_valid = valid_q;
	assign rsp_out   = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (rsp_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= rsp_in;
		end
	end

endmodule

@@ sv/ssu_ctrl.sv @@
// ----------------------------------------------------------------------------
// ssu_ctrl
// Command sequencer: checks, store writes and the lookup walk.
// ----------------------------------------------------------------------------
module ssu_ctrl (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cmd_valid,
	output logic                             cmd_ready,
	input  logic [ssu_pkg::CMD_BITS-1:0]     command,
	input  logic [ssu_pkg::KEY_BITS-1:0]     key,
	input  logic [ssu_pkg::VALUE_BITS-1:0]   bind_value,
	input  logic [ssu_pkg::DEPTH_BITS-1:0]   max_depth,
	output ssu_pkg::mem_req_t                mem_req,
	input  logic [ssu_pkg::MEM_BITS-1:0]     mem_rdata,
	input  logic                             slot_free,
	output logic                             rsp_load,
	output ssu_pkg::rsp_t                    rsp
);
	import ssu_pkg::*;

	state_t                state_q, state_d;
	cmd_t                  cmd_q, cmd_d;
	logic [KEY_BITS-1:0]   key_q, key_d;
	logic [DEPTH_BITS-1:0] depth_q, depth_d;
	logic [CNT_BITS-1:0]   used_q, used_d;
	logic [ADDR_BITS-1:0]  base_q, base_d;
	logic [CNT_BITS-1:0]   i_q, i_d;
	logic [WORD_BITS-1:0]  b_q, b_d;
	logic                  bnd_q, bnd_d;
	status_t               status_q, status_d;
	logic [VALUE_BITS-1:0] found_q, found_d;

	logic                  accept;
	cmd_t                  cmd_in;
	logic [CNT_BITS-1:0]   used_m1, used_m2, i_m1;
	logic                  rd_mark;
	logic [WORD_BITS-1:0]  rd_word;
	logic                  full1, full2, pop_bad, unst_bad, lk_end, i_bnd;
	logic                  key_hit, link_bad;

	assign cmd_ready = (state_q == S_IDLE);
	assign accept    = cmd_valid && cmd_ready;
	assign cmd_in    = cmd_t'(command);
	assign used_m1   = used_q - CNT_BITS'(1);
	assign used_m2   = used_q - CNT_BITS'(2);
	assign i_m1      = i_q - CNT_BITS'(1);
	assign rd_mark   = mem_rdata[MEM_BITS-1];
	assign rd_word   = mem_rdata[WORD_BITS-1:0];

	assign full1    = (used_q == CNT_BITS'(STORE_DEPTH));
	assign full2    = (used_q > CNT_BITS'(STORE_DEPTH - 2));
	assign pop_bad  = (used_q == '0) || ({1'b0, base_q} >= used_q);
	assign unst_bad = (used_q < CNT_BITS'(2));
	assign lk_end   = (i_q <= CNT_BITS'(2));
	assign i_bnd    = (WORD_BITS'(i_m1) == b_q);
	assign key_hit  = !rd_mark && (rd_word == WORD_BITS'(key_q));
	assign link_bad = (rd_word >= WORD_BITS'(i_q));

	assign rsp_load = (state_q == S_DONE) && slot_free;
	assign rsp      = '{status: status_q, found: found_q, used: used_q};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_DONE;
					case (cmd_in)
						CMD_POP:     if (!pop_bad) state_d = S_POP_RD;
						CMD_STASH,
						CMD_DEFINE:  if (!full2) state_d = S_WR2;
						CMD_UNSTASH: if (!unst_bad) state_d = S_UNS_MARK;
						CMD_LOOKUP:  state_d = S_LK_CHECK;
						default:     state_d = S_DONE;
					endcase
				end
			end
			S_WR2:      state_d = S_DONE;
			S_POP_RD:   state_d = S_DONE;
			S_UNS_MARK: state_d = rd_mark ? S_UNS_BASE : S_DONE;
			S_UNS_BASE: state_d = S_DONE;
			S_LK_CHECK: begin
				if (lk_end || (i_bnd && depth_q == '0)) begin
					state_d = S_DONE;
				end else begin
					state_d = S_LK_WORD;
				end
			end
			S_LK_WORD: begin
				if (bnd_q) begin
					state_d = rd_mark ? S_LK_LINK : S_LK_CHECK;
				end else begin
					state_d = key_hit ? S_LK_VAL : S_LK_CHECK;
				end
			end
			S_LK_LINK:  state_d = link_bad ? S_DONE : S_LK_BASE;
			S_LK_BASE:  state_d = S_LK_CHECK;
			S_LK_VAL:   state_d = S_DONE;
			S_DONE:     if (slot_free) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	// store requests and register updates
	always_comb begin
		mem_req  = '0;
		cmd_d    = cmd_q;
		key_d    = key_q;
		depth_d  = depth_q;
		used_d   = used_q;
		base_d   = base_q;
		i_d      = i_q;
		b_d      = b_q;
		bnd_d    = bnd_q;
		status_d = status_q;
		found_d  = found_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd_d    = cmd_in;
					key_d    = key;
					depth_d  = max_depth;
					status_d = ST_OK;
					found_d  = '0;
					i_d      = used_q;
					b_d      = WORD_BITS'(base_q);
					case (cmd_in)
						CMD_CLEAR: begin
							used_d = '0;
							base_d = '0;
						end
						CMD_PUSH: begin
							if (full1) begin
								status_d = ST_FULL;
							end else begin
								mem_req.we    = 1'b1;
								mem_req.waddr = used_q[ADDR_BITS-1:0];
								mem_req.wdata = {1'b0, WORD_BITS'(base_q)};
								base_d        = used_q[ADDR_BITS-1:0];
								used_d        = used_q + CNT_BITS'(1);
							end
						end
						CMD_POP: begin
							if (pop_bad) begin
								status_d = ST_MISUSE;
							end else begin
								mem_req.re    = 1'b1;
								mem_req.raddr = base_q;
							end
						end
						CMD_STASH: begin
							if (full2) begin
								status_d = ST_FULL;
							end else begin
								mem_req.we    = 1'b1;
								mem_req.waddr = used_q[ADDR_BITS-1:0];
								mem_req.wdata = {1'b0, WORD_BITS'(base_q)};
							end
						end
						CMD_UNSTASH: begin
							if (unst_bad) begin
								status_d = ST_MISUSE;
							end else begin
								mem_req.re    = 1'b1;
								mem_req.raddr = used_m1[ADDR_BITS-1:0];
							end
						end
						CMD_DEFINE: begin
							if (full2) begin
								status_d = ST_FULL;
							end else begin
								mem_req.we    = 1'b1;
								mem_req.waddr = used_q[ADDR_BITS-1:0];
								mem_req.wdata = {1'b0, WORD_BITS'(bind_value)};
							end
						end
						CMD_LOOKUP: status_d = ST_OK;
						default:    status_d = ST_MISUSE;
					endcase
				end
			end
			S_WR2: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = used_q[ADDR_BITS-1:0] + ADDR_BITS'(1);
				if (cmd_q == CMD_STASH) begin
					mem_req.wdata = {1'b1, WORD_BITS'(0)};
					base_d        = used_q[ADDR_BITS-1:0] + ADDR_BITS'(1);
				end else begin
					mem_req.wdata = {1'b0, WORD_BITS'(key_q)};
				end
				used_d = used_q + CNT_BITS'(2);
			end
			S_POP_RD: begin
				if (rd_mark) begin
					status_d = ST_MISUSE;
				end else begin
					used_d = {1'b0, base_q};
					base_d = rd_word[ADDR_BITS-1:0];
				end
			end
			S_UNS_MARK: begin
				if (!rd_mark) begin
					status_d = ST_MISUSE;
				end else begin
					mem_req.re    = 1'b1;
					mem_req.raddr = used_m2[ADDR_BITS-1:0];
				end
			end
			S_UNS_BASE: begin
				base_d = rd_word[ADDR_BITS-1:0];
				used_d = used_m2;
			end
			S_LK_CHECK: begin
				if (lk_end || (i_bnd && depth_q == '0)) begin
					status_d = ST_NOTFOUND;
				end else begin
					i_d           = i_m1;
					bnd_d         = i_bnd;
					mem_req.re    = 1'b1;
					mem_req.raddr = i_m1[ADDR_BITS-1:0];
					if (i_bnd) begin
						depth_d = depth_q - DEPTH_BITS'(1);
					end
				end
			end
			S_LK_WORD: begin
				if (bnd_q) begin
					if (rd_mark) begin
						mem_req.re    = 1'b1;
						mem_req.raddr = i_m1[ADDR_BITS-1:0];
					end else begin
						b_d = rd_word;   // boundary word holds parent base
					end
				end else if (key_hit) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = i_m1[ADDR_BITS-1:0];
				end else begin
					i_d = i_m1;   // skip the value word
				end
			end
			S_LK_LINK: begin
				if (link_bad) begin
					status_d = ST_NOTFOUND;
				end else begin
					i_d           = rd_word[CNT_BITS-1:0];
					mem_req.re    = 1'b1;
					mem_req.raddr = rd_word[ADDR_BITS-1:0];
				end
			end
			S_LK_BASE: b_d = rd_word;
			S_LK_VAL: begin
				status_d = ST_OK;
				found_d  = rd_word[VALUE_BITS-1:0];
			end
			S_DONE:  ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q  <= '0;
			base_q  <= '0;
		end else begin
			state_q <= state_d;
			used_q  <= used_d;
			base_q  <= base_d;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q    <= cmd_d;
		key_q    <= key_d;
		depth_q  <= depth_d;
		i_q      <= i_d;
		b_q      <= b_d;
		bnd_q    <= bnd_d;
		status_q <= status_d;
		found_q  <= found_d;
	end

endmodule

@@ sv/scoped_symbol_stack_unit.sv @@
// ----------------------------------------------------------------------------
// scoped_symbol_stack_unit
// Bounded stack of key/value bindings with nested and stashed scopes.
// ----------------------------------------------------------------------------
// Usage:
//  - Command channel (cmd_valid/cmd_ready): command, key, bind_value,
//    max_depth. One response transfer (rsp_valid/rsp_ready) per command:
//    status, found_value, stack_used.
//  - From command transfer to response: clear, push and any check that
//    needs no store read go straight to the result; stash and define add
//    a second store write; pop and an unstash refused on its mark add one
//    store read; unstash adds two. Lookup reads one binding, boundary or
//    stash link per step and the value on a hit via the single read port.
//  - One command in flight at a time; the next transfer is taken the cycle
//    after the result enters the response register.
//  - Reset empties the stack (count and scope base to zero). The store RAM
//    is not cleared; only words below the count are ever read.
//  - If the receiver stalls, the result waits in the response register; one
//    more command may execute and then waits for the register to free.
// ----------------------------------------------------------------------------
module scoped_symbol_stack_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cmd_valid,
	output logic                             cmd_ready,
	input  logic [ssu_pkg::CMD_BITS-1:0]     command,
	input  logic [ssu_pkg::KEY_BITS-1:0]     key,
	input  logic [ssu_pkg::VALUE_BITS-1:0]   bind_value,
	input  logic [ssu_pkg::DEPTH_BITS-1:0]   max_depth,
	output logic                             rsp_valid,
	input  logic                             rsp_ready,
	output logic [ssu_pkg::STAT_BITS-1:0]    status,
	output logic [ssu_pkg::VALUE_BITS-1:0]   found_value,
	output logic [ssu_pkg::CNT_BITS-1:0]     stack_used
);
	import ssu_pkg::*;

	mem_req_t            mem_req;
	logic [MEM_BITS-1:0] mem_rdata;
	logic                slot_free;
	logic                rsp_load;
	rsp_t                rsp_c;
	rsp_t                rsp_o;

	// store: {stash mark, data word}
	ssu_ram #(
		.WIDTH(MEM_BITS),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (mem_req.we),
		.waddr(mem_req.waddr),
		.wdata(mem_req.wdata),
		.re   (mem_req.re),
		.raddr(mem_req.raddr),
		.rdata(mem_rdata)
	);

	// sequencer: all read-modify-write of the store goes through here
	ssu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.command   (command),
		.key       (key),
		.bind_value(bind_value),
		.max_depth (max_depth),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata),
		.slot_free (slot_free),
		.rsp_load  (rsp_load),
		.rsp       (rsp_c)
	);

	// response register decouples a stalled receiver
	ssu_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (rsp_load),
		.rsp_in   (rsp_c),
		.slot_free(slot_free),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_out  (rsp_o)
	);

	assign status      = rsp_o.status;
	assign found_value = rsp_o.found;
	assign stack_used  = rsp_o.used;

	// the count can never exceed the store
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (stack_used <= CNT_BITS'(STORE_DEPTH)))
		else $error("stack_used beyond store depth");

	// only a successful lookup carries a value
	a_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status != ST_OK) |-> (found_value == '0))
		else $error("found_value set on failed command");

	// a taken command keeps the sequencer busy in the following cycle
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd_ready) |=> !cmd_ready)
		else $error("command taken while previous one in flight");

	// the store is never written and read in the same cycle
	a_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_req.we && mem_req.re))
		else $error("store write and read collide");

endmodule

@@ verif/scoped_symbol_stack_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scoped_symbol_stack_unit_tb
// Self-checking bench for the scoped symbol stack unit. Commands are pushed
// through the command channel with random gaps. A scoreboard keeps its own
// copy of the binding store and predicts each response. Responses are
// drained with random back-pressure and checked field by field.
// ----------------------------------------------------------------------------
module scoped_symbol_stack_unit_tb;

	import ssu_pkg::*;

	localparam int          N_ITEMS     = 1200;
	localparam int          KEY_POOL    = 12;
	localparam int          STALL_LIMIT = 20000; // cycles with no transfer at all
	localparam int          TAIL_CYCLES = 40;
	localparam logic [2:0]  CMD_UNDEFINED = 3'd7; // not in the enum, must give misuse

	// ------------------------------------------------------------------------
	// Scoreboard: private copy of the store, count and scope base; one
	// predicted response per accepted command, oldest first.
	// ------------------------------------------------------------------------
	class binding_scoreboard;
		logic [WORD_BITS-1:0] word_mem [STORE_DEPTH];
		bit                   mark_mem [STORE_DEPTH];
		int unsigned          used_words;
		int unsigned          base_idx;
		rsp_t                 rsp_due [$];
		int unsigned          errors;

		function new();
			foreach (word_mem[i]) begin
				word_mem[i] = '0;
				mark_mem[i] = 1'b0;
			end
			used_words = 0;
			base_idx   = 0;
			errors     = 0;
		endfunction

		function void store_word(int unsigned idx, logic [WORD_BITS-1:0] w, bit m);
			if (idx < STORE_DEPTH) begin
				word_mem[idx] = w;
				mark_mem[idx] = m;
			end
		endfunction

		// Walk down from the top; boundaries cost one unit of depth,
		// a stash boundary jumps to the link below it.
		function status_t walk_scopes(logic [KEY_BITS-1:0] k, int unsigned depth,
				output logic [VALUE_BITS-1:0] hit);
			int unsigned          i;
			int unsigned          left;
			logic [WORD_BITS-1:0] b;
			logic [WORD_BITS-1:0] link;
			i    = used_words;
			b    = base_idx;
			left = depth;
			hit  = '0;
			while (i > 2) begin
				i--;
				if (i == b) begin
					if (left == 0)
						break;
					left--;
					if (mark_mem[i]) begin
						link = word_mem[i-1];
						if (link >= i)
							break;  // broken link: give up
						i = link;
					end
					b = word_mem[i];
				end else begin
					if (!mark_mem[i] && word_mem[i] == k) begin
						hit = word_mem[i-1];
						return ST_OK;
					end
					i--;
				end
			end
			return ST_NOTFOUND;
		endfunction

		function rsp_t apply_command(logic [CMD_BITS-1:0] op, logic [KEY_BITS-1:0] k,
				logic [VALUE_BITS-1:0] v, logic [DEPTH_BITS-1:0] depth);
			rsp_t                  r;
			int unsigned           free_words;
			status_t               st;
			logic [VALUE_BITS-1:0] hit;
			free_words = STORE_DEPTH - used_words;
			st         = ST_OK;
			hit        = '0;
			case (op)
				CMD_CLEAR: begin
					used_words = 0;
					base_idx   = 0;
				end
				CMD_PUSH: begin
					if (free_words < 1) begin
						st = ST_FULL;
					end else begin
						store_word(used_words, base_idx, 1'b0);
						base_idx   = used_words;
						used_words = used_words + 1;
					end
				end
				CMD_POP: begin
					if (used_words == 0 || base_idx >= used_words || mark_mem[base_idx]) begin
						st = ST_MISUSE;
					end else begin
						used_words = base_idx;
						base_idx   = word_mem[base_idx] % STORE_DEPTH;
					end
				end
				CMD_STASH: begin
					if (free_words < 2) begin
						st = ST_FULL;
					end else begin
						store_word(used_words, base_idx, 1'b0);
						store_word(used_words + 1, '0, 1'b1);
						base_idx   = used_words + 1;
						used_words = used_words + 2;
					end
				end
				CMD_UNSTASH: begin
					if (used_words < 2 || !mark_mem[used_words-1]) begin
						st = ST_MISUSE;
					end else begin
						base_idx   = word_mem[used_words-2] % STORE_DEPTH;
						used_words = used_words - 2;
					end
				end
				CMD_DEFINE: begin
					if (free_words < 2) begin
						st = ST_FULL;
					end else begin
						store_word(used_words, v, 1'b0);
						store_word(used_words + 1, k, 1'b0);
						used_words = used_words + 2;
					end
				end
				CMD_LOOKUP: begin
					st = walk_scopes(k, depth, hit);
					if (st != ST_OK)
						hit = '0;
				end
				default: st = ST_MISUSE;
			endcase
			r.status = st;
			r.found  = hit;
			r.used   = used_words[CNT_BITS-1:0];
			return r;
		endfunction

		function void note_command(logic [CMD_BITS-1:0] op, logic [KEY_BITS-1:0] k,
				logic [VALUE_BITS-1:0] v, logic [DEPTH_BITS-1:0] depth);
			rsp_due.push_back(apply_command(op, k, v, depth));
		endfunction

		function void check_result(logic [STAT_BITS-1:0] st, logic [VALUE_BITS-1:0] fv,
				logic [CNT_BITS-1:0] used);
			rsp_t exp;
			if (rsp_due.size() == 0) begin
				errors++;
				$error("response transfer with nothing outstanding: status %0d", st);
				return;
			end
			exp = rsp_due.pop_front();
			if (exp.status !== st) begin
				errors++;
				$error("status: expected %0d, actual %0d", exp.status, st);
			end
			if (exp.found !== fv) begin
				errors++;
				$error("found_value: expected %h, actual %h", exp.found, fv);
			end
			if (exp.used !== used) begin
				errors++;
				$error("stack_used: expected %0d, actual %0d", exp.used, used);
			end
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Signals and DUT
	// ------------------------------------------------------------------------
	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  cmd_valid   = 1'b0;
	logic                  cmd_ready;
	logic [CMD_BITS-1:0]   command     = '0;
	logic [KEY_BITS-1:0]   key         = '0;
	logic [VALUE_BITS-1:0] bind_value  = '0;
	logic [DEPTH_BITS-1:0] max_depth   = '0;
	logic                  rsp_valid;
	logic                  rsp_ready   = 1'b0;
	logic [STAT_BITS-1:0]  status;
	logic [VALUE_BITS-1:0] found_value;
	logic [CNT_BITS-1:0]   stack_used;

	binding_scoreboard     sb = new();
	logic [KEY_BITS-1:0]   key_pool [KEY_POOL];
	int                    sent_count   = 0;
	int                    stall_cycles = 0;
	bit                    steady       = 1'b0; // no idling on either side while set

	scoped_symbol_stack_unit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.command     (command),
		.key         (key),
		.bind_value  (bind_value),
		.max_depth   (max_depth),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.status      (status),
		.found_value (found_value),
		.stack_used  (stack_used)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Response side: check every transfer, then pick the next ready value.
	// Values are read right after the edge, i.e. as the DUT saw them.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (rsp_valid && rsp_ready)
			sb.check_result(status, found_value, stack_used);
		rsp_ready <= steady || ($urandom_range(0, 99) >= 10);
	end

	// Watchdog: a hung handshake on either side ends the run.
	always @(posedge clk) begin
		if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Field pickers
	// ------------------------------------------------------------------------
	// Mostly keys from a small pool so that lookups hit; now and then a fresh one.
	function automatic logic [KEY_BITS-1:0] pool_key();
		if ($urandom_range(0, 99) < 85)
			return key_pool[$urandom_range(0, KEY_POOL - 1)];
		return $urandom();
	endfunction

	// Shallow depths mostly, plus the maximum and full-range values.
	function automatic logic [DEPTH_BITS-1:0] pick_depth();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return DEPTH_BITS'($urandom_range(0, 4));
		if (r < 80)
			return '1;
		return DEPTH_BITS'($urandom_range(0, (1 << DEPTH_BITS) - 1));
	endfunction

	// ------------------------------------------------------------------------
	// Command driver: one transfer per call. A random gap drops valid first;
	// otherwise valid simply stays high into the next transfer.
	// ------------------------------------------------------------------------
	task automatic send_cmd(logic [CMD_BITS-1:0] op, logic [KEY_BITS-1:0] k,
			logic [VALUE_BITS-1:0] v, logic [DEPTH_BITS-1:0] d);
		if (!steady && $urandom_range(0, 99) < 10) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		cmd_valid  <= 1'b1;
		command    <= op;
		key        <= k;
		bind_value <= v;
		max_depth  <= d;
		do @(posedge clk); while (!(cmd_valid && cmd_ready));
		sb.note_command(op, k, v, d);
		sent_count++;
		steady = (sent_count >= 250 && sent_count < 450);
	endtask

	// Commands that ignore key, value and depth still get random content there.
	task automatic send_bare(logic [CMD_BITS-1:0] op);
		send_cmd(op, $urandom(), $urandom(), pick_depth());
	endtask

	// Hold off the sender until every outstanding response has come back.
	task automatic drain_results();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (sb.rsp_due.size() != 0);
	endtask

	// ------------------------------------------------------------------------
	// Directed part: edge values, every command, misuse, stash skipping,
	// stray base and broken stash link.
	// ------------------------------------------------------------------------
	task automatic run_directed();
		logic [KEY_BITS-1:0] k_inner;
		k_inner = 32'h5A5A_00C3;
		send_bare(CMD_POP);                                   // empty stack
		send_bare(CMD_UNSTASH);                               // nothing stashed
		send_bare(CMD_UNDEFINED);
		send_cmd(CMD_LOOKUP, '0, $urandom(), '1);             // empty, not found
		send_cmd(CMD_DEFINE, '1, '0, '0);
		send_cmd(CMD_DEFINE, '0, '1, '1);
		send_cmd(CMD_LOOKUP, '1, '0, '0);
		send_cmd(CMD_LOOKUP, '0, '0, '0);
		send_bare(CMD_PUSH);
		send_cmd(CMD_DEFINE, k_inner, 32'h0000_0001, '0);
		send_cmd(CMD_LOOKUP, '0, '0, '0);                     // boundary, no depth left
		send_cmd(CMD_LOOKUP, '0, '0, 10'd1);
		send_bare(CMD_STASH);
		send_cmd(CMD_LOOKUP, '0, '0, '1);                     // jumps the stashed scope
		send_cmd(CMD_LOOKUP, k_inner, '0, '1);                // inner binding is hidden
		send_bare(CMD_POP);                                   // base is a stash mark
		send_bare(CMD_UNSTASH);
		send_bare(CMD_UNSTASH);                               // top is no longer a mark
		send_bare(CMD_POP);
		send_bare(CMD_CLEAR);
		// stray base: pop a value word as if it were a boundary
		send_cmd(CMD_DEFINE, k_inner, 32'h0000_01F4, '0);
		send_bare(CMD_POP);
		send_cmd(CMD_DEFINE, k_inner, 32'h0000_0007, '0);
		send_bare(CMD_STASH);                                 // link points above the mark
		send_cmd(CMD_LOOKUP, k_inner, '0, 10'd3);
		send_bare(CMD_CLEAR);
	endtask

	// ------------------------------------------------------------------------
	// Fill the store to the last word and hit every full case.
	// ------------------------------------------------------------------------
	task automatic run_fill();
		send_bare(CMD_CLEAR);
		while (sb.used_words < STORE_DEPTH - 2)
			send_cmd(CMD_DEFINE, pool_key(), $urandom(), pick_depth());
		send_bare(CMD_PUSH);                                  // one word left
		send_cmd(CMD_DEFINE, pool_key(), $urandom(), '0);
		send_bare(CMD_STASH);
		send_bare(CMD_PUSH);                                  // last word
		send_bare(CMD_PUSH);
		send_cmd(CMD_DEFINE, pool_key(), $urandom(), '0);
		send_cmd(CMD_LOOKUP, pool_key(), '0, '1);
		send_cmd(CMD_LOOKUP, $urandom(), '0, '1);             // long walk
		send_cmd(CMD_LOOKUP, pool_key(), '0, '0);
		send_bare(CMD_POP);
		send_bare(CMD_CLEAR);
	endtask

	// ------------------------------------------------------------------------
	// Random part: mostly well formed scope and stash blocks with random
	// content; the rest is define and lookup runs, noise, stray-base setups, lone pops and clears.
	// ------------------------------------------------------------------------
	task automatic scope_block();
		int n_def;
		int n_look;
		n_def  = $urandom_range(0, 4);
		n_look = $urandom_range(1, 4);
		send_bare(CMD_PUSH);
		repeat (n_def) send_cmd(CMD_DEFINE, pool_key(), $urandom(), pick_depth());
		repeat (n_look) send_cmd(CMD_LOOKUP, pool_key(), $urandom(), pick_depth());
		if ($urandom_range(0, 3) != 0)
			send_bare(CMD_POP);
	endtask

	task automatic stash_block();
		int n_def;
		int n_look;
		bit pushed;
		n_def  = $urandom_range(0, 3);
		n_look = $urandom_range(1, 3);
		pushed = ($urandom_range(0, 9) < 6);
		send_bare(CMD_STASH);
		if (pushed)
			send_bare(CMD_PUSH);
		repeat (n_def) send_cmd(CMD_DEFINE, pool_key(), $urandom(), pick_depth());
		repeat (n_look) send_cmd(CMD_LOOKUP, pool_key(), $urandom(), pick_depth());
		if (pushed && $urandom_range(0, 9) < 8)
			send_bare(CMD_POP);
		// after defines straight into the stash this turns into misuse
		if ($urandom_range(0, 9) < 7)
			send_bare(CMD_UNSTASH);
	endtask

	task automatic stray_block();
		int n_def;
		n_def = $urandom_range(0, 6);
		send_bare(CMD_CLEAR);
		send_cmd(CMD_DEFINE, pool_key(), $urandom_range(0, 30), pick_depth());
		send_bare(CMD_POP);
		repeat (n_def) send_cmd(CMD_DEFINE, pool_key(), $urandom_range(0, 40), pick_depth());
	endtask

	task automatic run_random();
		int  r;
		bit  filled;
		filled = 1'b0;
		while (sent_count < N_ITEMS) begin
			if (!filled && sent_count >= 600) begin
				drain_results();                              // sender holds off here
				run_fill();
				filled = 1'b1;
			end else if (sb.used_words > 400) begin
				send_bare(CMD_CLEAR);
			end else begin
				r = $urandom_range(0, 99);
				if (r < 40)
					scope_block();
				else if (r < 55)
					stash_block();
				else if (r < 80)
					repeat (3) send_cmd(($urandom_range(0, 1) != 0) ? CMD_DEFINE : CMD_LOOKUP,
						pool_key(), $urandom(), pick_depth());
				else if (r < 88)
					send_cmd(CMD_BITS'($urandom_range(0, 7)), $urandom(), $urandom(),
						DEPTH_BITS'($urandom_range(0, (1 << DEPTH_BITS) - 1)));
				else if (r < 93)
					stray_block();
				else
					send_bare(CMD_POP);
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		key_pool[0] = '0;
		key_pool[1] = '1;
		key_pool[2] = 32'd1;
		key_pool[3] = 32'd2;
		key_pool[4] = 32'd3;
		for (int i = 5; i < KEY_POOL; i++)
			key_pool[i] = $urandom();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		drain_results();
		run_random();

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);   // anything late shows up as unexpected
		if (sb.rsp_due.size() != 0)
			$error("%0d responses never arrived", sb.rsp_due.size());
		if (sb.errors == 0 && sb.rsp_due.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ files.f @@
sv/ssu_pkg.sv
sv/ssu_ram.sv
sv/ssu_out_reg.sv
sv/ssu_ctrl.sv
sv/scoped_symbol_stack_unit.sv
verif/scoped_symbol_stack_unit_tb.sv
